FILE: rtl/sha1bc_pkg.sv
// shared types, constants and round functions for the sha-1 block compression pipeline
package sha1bc_pkg;

    localparam int NumRounds = 80;
    localparam int GroupLen  = 20;
    localparam int WinWords  = 16;

    typedef logic [31:0] t_word;
    typedef t_word [WinWords-1:0] t_win;

    typedef struct packed {
        t_word a;
        t_word b;
        t_word c;
        t_word d;
        t_word e;
    } t_state;

    typedef struct packed {
        logic en;
        logic valid;
    } t_pipe_ctl;

    localparam t_word IvA = 32'h67452301;
    localparam t_word IvB = 32'hEFCDAB89;
    localparam t_word IvC = 32'h98BADCFE;
    localparam t_word IvD = 32'h10325476;
    localparam t_word IvE = 32'hC3D2E1F0;

    localparam t_state IvState = '{a: IvA, b: IvB, c: IvC, d: IvD, e: IvE};

    localparam logic [1:0] GrpChoose = 2'd0;
    localparam logic [1:0] GrpParity = 2'd1;
    localparam logic [1:0] GrpMajor  = 2'd2;
    localparam logic [1:0] GrpParLate = 2'd3;

    function automatic t_word round_k(input logic [1:0] grp);
        t_word k;
        unique case (grp)
            GrpChoose:  k = 32'h5A827999;
            GrpParity:  k = 32'h6ED9EBA1;
            GrpMajor:   k = 32'h8F1BBCDC;
            GrpParLate: k = 32'hCA62C1D6;
            default:    k = 32'hCA62C1D6;
        endcase
        return k;
    endfunction

    function automatic t_word round_mix(input logic [1:0] grp, input t_word b,
                                        input t_word c, input t_word d);
        t_word f;
        unique case (grp)
            GrpChoose:  f = (b & c) | (~b & d);
            GrpMajor:   f = (b & c) | (b & d) | (c & d);
            GrpParity:  f = b ^ c ^ d;
            GrpParLate: f = b ^ c ^ d;
            default:    f = b ^ c ^ d;
        endcase
        return f;
    endfunction

endpackage

FILE: rtl/sha1bc_round.sv
// one registered sha-1 round with its sliding message schedule window
module sha1bc_round #(
    parameter int RoundIdx = 0
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  sha1bc_pkg::t_pipe_ctl i_ctl,
    input  sha1bc_pkg::t_state    i_state,
    input  sha1bc_pkg::t_win      i_win,
    output logic                  o_valid,
    output sha1bc_pkg::t_state    o_state,
    output sha1bc_pkg::t_win      o_win
);

    localparam logic [1:0] Grp = 2'(RoundIdx / sha1bc_pkg::GroupLen);

    logic               r_valid;
    sha1bc_pkg::t_state r_state;
    sha1bc_pkg::t_win   r_win;
    sha1bc_pkg::t_state n_state;
    sha1bc_pkg::t_win   n_win;
    sha1bc_pkg::t_word  mix;
    sha1bc_pkg::t_word  fb;

    assign mix = sha1bc_pkg::round_mix(Grp, i_state.b, i_state.c, i_state.d);

    // next schedule word w[t+16] from w[t+13], w[t+8], w[t+2], w[t]
    assign fb = i_win[13] ^ i_win[8] ^ i_win[2] ^ i_win[0];

    always_comb begin
        n_state.a = {i_state.a[26:0], i_state.a[31:27]} + mix + i_state.e
                    + i_win[0] + sha1bc_pkg::round_k(Grp);
        n_state.b = i_state.a;
        n_state.c = {i_state.b[1:0], i_state.b[31:2]};
        n_state.d = i_state.c;
        n_state.e = i_state.d;
        for (int i = 0; i < sha1bc_pkg::WinWords - 1; i++) begin
            n_win[i] = i_win[i+1];
        end
        n_win[sha1bc_pkg::WinWords-1] = {fb[30:0], fb[31]};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_ctl.en) begin
            r_valid <= i_ctl.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.en) begin
            r_state <= n_state;
            r_win   <= n_win;
        end
    end

    assign o_valid = r_valid;
    assign o_state = r_state;
    assign o_win   = r_win;

endmodule

FILE: rtl/sha1_block_compress.sv
// sha-1 single-block compression: 80 pipelined rounds and a final add stage
// Takes one padded 512-bit block per beat and returns its SHA-1 digest, always from the
// standard initial values with no chaining. One round sits in each of 80 register stages,
// followed by an output register holding the feed-forward sum. A new block can be accepted
// every cycle while o_stall is low. The whole pipeline moves as one: o_stall rises only
// while a result is waiting in the output register and i_stall holds it, and then every
// stage holds its contents.
module sha1_block_compress (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [63:0] i_block_pair_0,
    input  logic [63:0] i_block_pair_1,
    input  logic [63:0] i_block_pair_2,
    input  logic [63:0] i_block_pair_3,
    input  logic [63:0] i_block_pair_4,
    input  logic [63:0] i_block_pair_5,
    input  logic [63:0] i_block_pair_6,
    input  logic [63:0] i_block_pair_7,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [31:0] o_digest_word_a,
    output logic [31:0] o_digest_word_b,
    output logic [31:0] o_digest_word_c,
    output logic [31:0] o_digest_word_d,
    output logic [31:0] o_digest_word_e
);

    localparam int N = sha1bc_pkg::NumRounds;

    logic               adv;
    logic               stg_valid [0:N];
    sha1bc_pkg::t_state stg_state [0:N];
    sha1bc_pkg::t_win   stg_win   [0:N];

    logic               r_out_valid;
    sha1bc_pkg::t_state r_digest;
    sha1bc_pkg::t_state n_digest;

    assign adv     = !r_out_valid || !i_stall;
    assign o_stall = !adv;

    assign stg_valid[0] = i_valid;
    assign stg_state[0] = sha1bc_pkg::IvState;

    // big-endian words: upper half of each pair is the even word
    assign stg_win[0][0]  = i_block_pair_0[63:32];
    assign stg_win[0][1]  = i_block_pair_0[31:0];
    assign stg_win[0][2]  = i_block_pair_1[63:32];
    assign stg_win[0][3]  = i_block_pair_1[31:0];
    assign stg_win[0][4]  = i_block_pair_2[63:32];
    assign stg_win[0][5]  = i_block_pair_2[31:0];
    assign stg_win[0][6]  = i_block_pair_3[63:32];
    assign stg_win[0][7]  = i_block_pair_3[31:0];
    assign stg_win[0][8]  = i_block_pair_4[63:32];
    assign stg_win[0][9]  = i_block_pair_4[31:0];
    assign stg_win[0][10] = i_block_pair_5[63:32];
    assign stg_win[0][11] = i_block_pair_5[31:0];
    assign stg_win[0][12] = i_block_pair_6[63:32];
    assign stg_win[0][13] = i_block_pair_6[31:0];
    assign stg_win[0][14] = i_block_pair_7[63:32];
    assign stg_win[0][15] = i_block_pair_7[31:0];

    for (genvar k = 0; k < N; k++) begin : g_round
        sha1bc_pkg::t_pipe_ctl ctl;

        assign ctl.en    = adv;
        assign ctl.valid = stg_valid[k];

        sha1bc_round #(
            .RoundIdx (k)
        ) u_round (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_ctl   (ctl),
            .i_state (stg_state[k]),
            .i_win   (stg_win[k]),
            .o_valid (stg_valid[k+1]),
            .o_state (stg_state[k+1]),
            .o_win   (stg_win[k+1])
        );
    end

    always_comb begin
        n_digest.a = stg_state[N].a + sha1bc_pkg::IvA;
        n_digest.b = stg_state[N].b + sha1bc_pkg::IvB;
        n_digest.c = stg_state[N].c + sha1bc_pkg::IvC;
        n_digest.d = stg_state[N].d + sha1bc_pkg::IvD;
        n_digest.e = stg_state[N].e + sha1bc_pkg::IvE;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (adv) begin
            r_out_valid <= stg_valid[N];
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_digest <= n_digest;
        end
    end

    assign o_valid         = r_out_valid;
    assign o_digest_word_a = r_digest.a;
    assign o_digest_word_b = r_digest.b;
    assign o_digest_word_c = r_digest.c;
    assign o_digest_word_d = r_digest.d;
    assign o_digest_word_e = r_digest.e;

endmodule

FILE: rtl/sha1bc_checker.sv
// port-level checks for the sha-1 block compression pipeline, bound to the top level
module sha1bc_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_stall,
    input logic        o_valid,
    input logic        i_stall,
    input logic [31:0] o_digest_word_a,
    input logic [31:0] o_digest_word_b,
    input logic [31:0] o_digest_word_c,
    input logic [31:0] o_digest_word_d,
    input logic [31:0] o_digest_word_e
);

    // input side is held back only by a waiting result beat
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> (o_valid && i_stall))
        else $error("input stalled without a blocked result");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result valid right after reset");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=> o_valid)
        else $error("stalled result beat dropped");

    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=> ($stable(o_digest_word_a) && $stable(o_digest_word_b)
            && $stable(o_digest_word_c) && $stable(o_digest_word_d)
            && $stable(o_digest_word_e)))
        else $error("stalled digest changed");

endmodule

bind sha1_block_compress sha1bc_checker u_sha1bc_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .o_stall         (o_stall),
    .o_valid         (o_valid),
    .i_stall         (i_stall),
    .o_digest_word_a (o_digest_word_a),
    .o_digest_word_b (o_digest_word_b),
    .o_digest_word_c (o_digest_word_c),
    .o_digest_word_d (o_digest_word_d),
    .o_digest_word_e (o_digest_word_e)
);
